/* hdl/assert_macros.svh */
// Assertion macros shared by the checker modules of the project.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("Checker assertion failed.");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("Checker assertion failed.");

`endif

/* hdl/bcc_pkg.sv */
// Shared types and constants for the button click classifier.
// No dependencies; used by the update logic, the top level and the checker.
package bcc_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam logic [2:0] BTN_COUNT = 3'(NUM_BUTTONS);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_GAP  = 2'd2;

   localparam logic [7:0]  DEBOUNCE_RESET   = 8'd3;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd30;
   localparam logic [15:0] CLICK_GAP_RESET  = 16'd15;

   localparam logic [7:0]  COUNT8_MAX  = 8'hFF;
   localparam logic [15:0] COUNT16_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DOWN = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } ev_kind_type;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] long_press_ticks;
      logic [15:0] click_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic        stable_level;
      logic [7:0]  mismatch_count;
      logic [15:0] tick_count;
      phase_type   click_phase;
      logic [7:0]  press_repeats;
   } btn_state_type;

endpackage

/* hdl/button_click_classifier.sv */
// Top level of the button click classifier: input register, per-button state,
// LED register and result register. Depends on bcc_pkg and bcc_button_update.
//
// Each request transaction is one scan tick of one active-low button; each
// tick yields exactly one response transaction carrying the event it closed
// (none, single click, double click or long press), the button index and the
// LED toggle register after the tick. While rsp_ready keeps up, the block
// sustains one transaction per clock cycle: a tick is captured in an input
// register, and when it advances the per-button update logic reads that
// button's state, writes the new state back and loads the result register at
// the same clock edge, so a tick of the same button right behind it already
// sees the updated state. A response passes the input register and then the
// result register, where it is held until rsp_ready takes it.
// The input register keeps accepting while a finished response waits for
// rsp_ready, and stalls only when both registers are occupied. Configuration
// writes take effect at the clock edge where csr_wr_en is high and should be
// issued only while no transaction is in flight. All state resets at once;
// there is no clearing pass.
module button_click_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_button_index,
   input  logic                            req_raw_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_event_kind,
   output logic [1:0]                      rsp_event_button,
   output logic [7:0]                      rsp_led_bits,
   input  logic                            csr_wr_en,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   // Configuration registers.
   bcc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bcc_pkg::CSR_DEBOUNCE:   cfg_in.debounce_ticks   = csr_wr_data[7:0];
            bcc_pkg::CSR_LONG_PRESS: cfg_in.long_press_ticks = csr_wr_data;
            bcc_pkg::CSR_CLICK_GAP:  cfg_in.click_gap_ticks  = csr_wr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= bcc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= bcc_pkg::LONG_PRESS_RESET;
         cfg_ff.click_gap_ticks  <= bcc_pkg::CLICK_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register and the handshake that moves it into the result register.
   logic       in_valid_ff;
   logic [1:0] in_index_ff;
   logic       in_raw_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_accept;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_index_ff <= req_button_index;
         in_raw_ff   <= req_raw_level;
      end
   end

   // Per-button state and the update for the button of the held tick.
   bcc_pkg::btn_state_type btn_ff [bcc_pkg::NUM_BUTTONS];
   bcc_pkg::btn_state_type btn_cur;
   bcc_pkg::btn_state_type btn_nxt;
   bcc_pkg::ev_kind_type   upd_ev;
   bcc_pkg::ev_kind_type   ev_in;
   logic [bcc_pkg::BTN_IDX_W-1:0] sel;
   logic                          in_hit;

   // A tick for an index beyond the configured buttons changes nothing.
   assign in_hit  = ({1'b0, in_index_ff} < bcc_pkg::BTN_COUNT);
   assign sel     = in_index_ff[bcc_pkg::BTN_IDX_W-1:0];
   assign btn_cur = btn_ff[sel];

   bcc_button_update u_update (
      .cfg       (cfg_ff),
      .cur       (btn_cur),
      .raw_level (in_raw_ff),
      .nxt       (btn_nxt),
      .ev        (upd_ev)
   );

   assign ev_in = in_hit ? upd_ev : bcc_pkg::EV_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bcc_pkg::NUM_BUTTONS; k++) begin
            btn_ff[k].stable_level   <= 1'b1;
            btn_ff[k].mismatch_count <= 8'd0;
            btn_ff[k].tick_count     <= 16'd0;
            btn_ff[k].click_phase    <= bcc_pkg::PH_IDLE;
            btn_ff[k].press_repeats  <= 8'd0;
         end
      end else if (advance && in_hit) begin
         btn_ff[sel] <= btn_nxt;
      end
   end

   // LED toggle register. A long press or a double click flips the button's
   // own bit; a single click flips the bit four places above it.
   logic [7:0] led_ff, led_in;
   logic [2:0] led_bit;

   always_comb begin
      led_bit = (ev_in == bcc_pkg::EV_SINGLE) ? {1'b1, in_index_ff} : {1'b0, in_index_ff};
      led_in  = led_ff;
      if (ev_in != bcc_pkg::EV_NONE) begin
         led_in = led_ff ^ (8'd1 << led_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff <= 8'd0;
      end else if (advance) begin
         led_ff <= led_in;
      end
   end

   // Result register.
   logic [1:0] rsp_kind_ff;
   logic [1:0] rsp_button_ff;
   logic [7:0] rsp_led_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff   <= ev_in;
         rsp_button_ff <= in_index_ff;
         rsp_led_ff    <= led_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_event_button = rsp_button_ff;
   assign rsp_led_bits     = rsp_led_ff;

endmodule

/* hdl/bcc_button_update.sv */
// Next-state and event logic for one button on one scan tick.
// Depends on bcc_pkg for the state, configuration and event types.
module bcc_button_update (
   input  bcc_pkg::cfg_type       cfg,
   input  bcc_pkg::btn_state_type cur,
   input  logic                   raw_level,
   output bcc_pkg::btn_state_type nxt,
   output bcc_pkg::ev_kind_type   ev
);

   always_comb begin
      logic [7:0]  mc_inc;
      logic [15:0] tc;
      nxt = cur;
      ev  = bcc_pkg::EV_NONE;

      // Ticks only run while a click sequence is open.
      tc = cur.tick_count;
      if (cur.click_phase != bcc_pkg::PH_IDLE && tc != bcc_pkg::COUNT16_MAX) begin
         tc = tc + 16'd1;
      end
      nxt.tick_count = tc;

      if (cur.stable_level != raw_level) begin
         mc_inc = (cur.mismatch_count == bcc_pkg::COUNT8_MAX) ?
                  cur.mismatch_count : cur.mismatch_count + 8'd1;
         if (mc_inc >= cfg.debounce_ticks) begin
            nxt.stable_level   = raw_level;
            nxt.mismatch_count = 8'd0;
         end else begin
            nxt.mismatch_count = mc_inc;
         end
      end else begin
         mc_inc             = 8'd0;
         nxt.mismatch_count = 8'd0;
      end

      case (cur.click_phase)
         bcc_pkg::PH_DOWN: begin
            if (nxt.stable_level) begin
               if (tc >= cfg.long_press_ticks) begin
                  ev              = bcc_pkg::EV_LONG;
                  nxt.click_phase = bcc_pkg::PH_IDLE;
               end else begin
                  nxt.tick_count  = 16'd0;
                  nxt.click_phase = bcc_pkg::PH_GAP;
               end
            end else if (tc >= cfg.long_press_ticks) begin
               nxt.press_repeats = 8'd0;
            end
         end
         bcc_pkg::PH_GAP: begin
            if (tc >= cfg.click_gap_ticks) begin
               nxt.click_phase = bcc_pkg::PH_IDLE;
               if (cur.press_repeats == 8'd1) begin
                  ev = bcc_pkg::EV_SINGLE;
               end else if (cur.press_repeats == 8'd2) begin
                  ev = bcc_pkg::EV_DOUBLE;
               end
            end else if (!nxt.stable_level) begin
               if (cur.press_repeats != bcc_pkg::COUNT8_MAX) begin
                  nxt.press_repeats = cur.press_repeats + 8'd1;
               end
               nxt.tick_count  = 16'd0;
               nxt.click_phase = bcc_pkg::PH_DOWN;
            end
         end
         default: begin
            // Idle, and the unused phase code, which behaves as idle.
            if (!nxt.stable_level) begin
               nxt.tick_count    = 16'd0;
               nxt.press_repeats = 8'd1;
               nxt.click_phase   = bcc_pkg::PH_DOWN;
            end
         end
      endcase
   end

endmodule

/* hdl/bcc_checker.sv */
// Port-level checker for the button click classifier, bound to the top level.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event_kind,
   input logic [1:0] rsp_event_button,
   input logic [7:0] rsp_led_bits
);

   // LED value of the last delivered response transaction.
   logic [7:0] last_led_ff, last_led_in;
   logic [7:0] led_diff;

   assign last_led_in = (rsp_valid && rsp_ready) ? rsp_led_bits : last_led_ff;
   assign led_diff    = rsp_led_bits ^ last_led_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_led_ff <= 8'd0;
      end else begin
         last_led_ff <= last_led_in;
      end
   end

   // A stalled response holds its payload.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) && $stable(rsp_event_button) && $stable(rsp_led_bits))

   // Without an event the LEDs are those of the previous response.
   `ASSERT_CLK_RST(a_led_quiet, clock, reset, rsp_valid && rsp_event_kind == bcc_pkg::EV_NONE |-> led_diff == 8'd0)

   // A long press or double click flips the button's bit, a single click the upper one.
   `ASSERT_CLK_RST(a_led_flip, clock, reset, rsp_valid && rsp_event_kind != bcc_pkg::EV_NONE |-> led_diff == ((rsp_event_kind == bcc_pkg::EV_SINGLE) ? (8'h10 << rsp_event_button) : (8'h01 << rsp_event_button)))

   // With the result register empty the block always takes a request.
   `ASSERT_CLK_RST(a_req_free, clock, reset, !rsp_valid |-> req_ready)

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_event_button (rsp_event_button),
   .rsp_led_bits     (rsp_led_bits)
);

/* dv/bcc_tb_pkg.sv */
// Scoreboard for the button click classifier bench: a per-button click predictor
// and the queue of response transactions it expects, checked in arrival order.
// Depends on bcc_pkg for the register layout, state layout and event codes.
package bcc_tb_pkg;
   import bcc_pkg::*;

   typedef struct {
      ev_kind_type kind;
      logic [1:0]  button;
      logic [7:0]  leds;
   } click_result_type;

   class click_scoreboard;
      cfg_type          regs;
      btn_state_type    buttons [NUM_BUTTONS];
      logic [7:0]       led_reg;
      click_result_type awaited [$];
      int               error_total;
      int               ticks_seen;
      int               event_tally [4];

      function new();
         regs.debounce_ticks   = DEBOUNCE_RESET;
         regs.long_press_ticks = LONG_PRESS_RESET;
         regs.click_gap_ticks  = CLICK_GAP_RESET;
         foreach (buttons[k]) begin
            buttons[k].stable_level   = 1'b1;
            buttons[k].mismatch_count = '0;
            buttons[k].tick_count     = '0;
            buttons[k].click_phase    = PH_IDLE;
            buttons[k].press_repeats  = '0;
         end
         led_reg     = '0;
         error_total = 0;
         ticks_seen  = 0;
         foreach (event_tally[k]) event_tally[k] = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DEBOUNCE:   regs.debounce_ticks   = data[7:0];
            CSR_LONG_PRESS: regs.long_press_ticks = data;
            CSR_CLICK_GAP:  regs.click_gap_ticks  = data;
            default: ;
         endcase
      endfunction

      // Advance the state of one button by one scan tick and queue the response.
      function void note_tick(logic [1:0] btn, logic raw);
         btn_state_type    s;
         click_result_type r;
         r.kind = EV_NONE;
         if (int'(btn) < NUM_BUTTONS) begin
            s = buttons[btn];
            if (s.click_phase != PH_IDLE && s.tick_count != COUNT16_MAX)
               s.tick_count = s.tick_count + 16'd1;

            if (s.stable_level != raw) begin
               if (s.mismatch_count != COUNT8_MAX)
                  s.mismatch_count = s.mismatch_count + 8'd1;
               if (s.mismatch_count >= regs.debounce_ticks) begin
                  s.stable_level   = raw;
                  s.mismatch_count = '0;
               end
            end else begin
               s.mismatch_count = '0;
            end

            case (s.click_phase)
               PH_DOWN: begin
                  if (s.stable_level) begin
                     if (s.tick_count >= regs.long_press_ticks) begin
                        led_reg[{1'b0, btn}] = ~led_reg[{1'b0, btn}];
                        r.kind        = EV_LONG;
                        s.click_phase = PH_IDLE;
                     end else begin
                        s.tick_count  = '0;
                        s.click_phase = PH_GAP;
                     end
                  end else if (s.tick_count >= regs.long_press_ticks) begin
                     s.press_repeats = '0;
                  end
               end
               PH_GAP: begin
                  if (s.tick_count >= regs.click_gap_ticks) begin
                     s.click_phase = PH_IDLE;
                     if (s.press_repeats == 8'd1) begin
                        led_reg[{1'b1, btn}] = ~led_reg[{1'b1, btn}];
                        r.kind = EV_SINGLE;
                     end else if (s.press_repeats == 8'd2) begin
                        led_reg[{1'b0, btn}] = ~led_reg[{1'b0, btn}];
                        r.kind = EV_DOUBLE;
                     end
                  end else if (!s.stable_level) begin
                     if (s.press_repeats != COUNT8_MAX)
                        s.press_repeats = s.press_repeats + 8'd1;
                     s.tick_count  = '0;
                     s.click_phase = PH_DOWN;
                  end
               end
               default: begin
                  if (!s.stable_level) begin
                     s.tick_count    = '0;
                     s.press_repeats = 8'd1;
                     s.click_phase   = PH_DOWN;
                  end
               end
            endcase
            buttons[btn] = s;
         end
         r.button = btn;
         r.leds   = led_reg;
         awaited.push_back(r);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(string what);
         error_total++;
         $display("MISMATCH %0d: %s", error_total, what);
      endtask

      task check_result(logic [1:0] kind, logic [1:0] button, logic [7:0] leds);
         click_result_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf(
               "response with nothing pending: kind %0d button %0d leds %02h",
               kind, button, leds));
            return;
         end
         want = awaited.pop_front();
         ticks_seen++;
         if (!$isunknown(kind))
            event_tally[kind]++;
         if (kind !== 2'(want.kind))
            report_mismatch($sformatf("response %0d event_kind %0d, predicted %0d",
                                      ticks_seen, kind, want.kind));
         if (button !== want.button)
            report_mismatch($sformatf("response %0d event_button %0d, predicted %0d",
                                      ticks_seen, button, want.button));
         if (leds !== want.leds)
            report_mismatch($sformatf("response %0d led_bits %02h, predicted %02h",
                                      ticks_seen, leds, want.leds));
      endtask
   endclass

endpackage

/* dv/tb_top.sv */
// Top of the button click classifier bench: clock, reset, request driver,
// response pacing, monitor and watchdog around the DUT.
// Depends on bcc_pkg, bcc_tb_pkg and the RTL top button_click_classifier.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bcc_pkg::*;
   import bcc_tb_pkg::*;

   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 8;    // Margin for responses still in flight.
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SPAN_CAP        = 200;
   localparam int REPEAT_CLICKS   = 257;  // Enough presses that a wrapped 8-bit count would read one.

   typedef enum {PACE_OPEN, PACE_HALF, PACE_MOSTLY, PACE_SPARSE} pace_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_button_index;
   logic                  req_raw_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_event_kind;
   logic [1:0]            rsp_event_button;
   logic [7:0]            rsp_led_bits;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   click_scoreboard tracker = new();

   // Per-button gesture plan for the random part: the level each button is
   // currently being held at and how many more of its ticks that lasts.
   logic plan_level [NUM_BUTTONS];
   int   plan_left  [NUM_BUTTONS];

   int   burst_left = 0;
   int   settings_total = 0;
   int   quiet_cycles = 0;
   bit   hold_off_pending = 1'b0;
   int   hold_offs_done = 0;

   button_click_classifier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_index (req_button_index),
      .req_raw_level    (req_raw_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_button (rsp_event_button),
      .rsp_led_bits     (rsp_led_bits),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one tick and hold it until the request transaction is accepted.
   // Called right after a rising edge; returns at the edge of acceptance, so a
   // following call keeps req_valid high without a dip.
   task automatic send_tick(input logic [1:0] btn, input logic raw);
      req_valid        <= 1'b1;
      req_button_index <= btn;
      req_raw_level    <= raw;
      do @(posedge clock); while (!req_ready);
      tracker.note_tick(btn, raw);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // The sender works in bursts of random length; between bursts it usually
   // pauses, sometimes not at all.
   task automatic send_paced(input logic [1:0] btn, input logic raw);
      send_tick(btn, raw);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0)
            idle_sender($urandom_range(1, 8));
      end
   endtask

   // Back-to-back ticks of one button, levels given as a string of 0s and 1s.
   task automatic press_pattern(input logic [1:0] btn, input string levels);
      for (int i = 0; i < levels.len(); i++)
         send_tick(btn, levels.getc(i) == "1");
   endtask

   // Stop offering and wait until every predicted response has arrived, then
   // let SETTLE_CYCLES pass so nothing is still in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers are only rewritten while the block is drained. The three writes
   // go out on consecutive edges with the write enable held high throughout.
   task automatic change_settings(input logic [7:0] deb, input logic [15:0] lp,
                                  input logic [15:0] gap);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_DEBOUNCE;
      csr_wr_data <= {8'h00, deb};
      @(posedge clock);
      csr_index   <= CSR_LONG_PRESS;
      csr_wr_data <= lp;
      @(posedge clock);
      csr_index   <= CSR_CLICK_GAP;
      csr_wr_data <= gap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.set_register(CSR_DEBOUNCE, {8'h00, deb});
      tracker.set_register(CSR_LONG_PRESS, lp);
      tracker.set_register(CSR_CLICK_GAP, gap);
      settings_total++;
   endtask

   // Random part under one register setting. Most ticks follow a gesture plan
   // per button: alternating press and release spans whose lengths straddle
   // the long-press and click-gap thresholds, so single, double, triple and
   // long presses all occur. Some ticks are contact bounce, some pure noise.
   task automatic run_phase(input logic [7:0] deb, input logic [15:0] lp,
                            input logic [15:0] gap, input int count, input bit hold);
      int   b;
      int   span;
      logic lvl;
      change_settings(deb, lp, gap);
      if (hold)
         hold_off_pending = 1'b1;
      for (int sent = 0; sent < count; sent++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_paced(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end else begin
            b = $urandom_range(0, NUM_BUTTONS - 1);
            if (plan_left[b] == 0) begin
               plan_level[b] = ~plan_level[b];
               span = plan_level[b] ? 2 * int'(gap) : 2 * int'(lp);
               span = span + int'(deb);
               if (span > SPAN_CAP)
                  span = SPAN_CAP;
               plan_left[b] = $urandom_range(1, span);
            end
            plan_left[b]--;
            lvl = plan_level[b];
            if ($urandom_range(0, 11) == 0)
               lvl = ~lvl;
            send_paced(2'(b), lvl);
         end
      end
   endtask

   initial begin : stimulus
      req_valid        <= 1'b0;
      req_button_index <= '0;
      req_raw_level    <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= '0;
      csr_wr_data      <= '0;
      reset            <= 1'b1;
      foreach (plan_level[k]) begin
         plan_level[k] = 1'b1;
         plan_left[k]  = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // With the reset debounce of three, two pressed samples are only bounce
      // and must not start a press.
      press_pattern(2'd3, "001");

      // Short thresholds so each gesture fits in a handful of ticks.
      change_settings(8'd1, 16'd4, 16'd2);
      press_pattern(2'd0, "0111");      // Single click.
      press_pattern(2'd1, "010111");    // Double click.
      press_pattern(2'd2, "000001");    // Long press.
      press_pattern(2'd3, "01010111");  // Three clicks give no event.

      run_phase(8'd2,   16'd12,    16'd6,     80,  1'b0);
      run_phase(8'd1,   16'd1,     16'd1,     50,  1'b0);
      // Zero debounce takes a mismatching level on its first sample.
      run_phase(8'd0,   16'd5,     16'd3,     50,  1'b0);
      run_phase(8'd4,   16'd20,    16'd10,    80,  1'b0);
      run_phase(8'd255, 16'hFFFF,  16'hFFFF,  40,  1'b0);
      // The reset setting again, with a long receiver hold-off early on so the
      // block fills up and pushes back on the request side.
      run_phase(8'd3,   16'd30,    16'd15,    110, 1'b1);

      // The repeat count must stick at its ceiling: a wrapped count would end
      // the sequence as a single click.
      change_settings(8'd1, 16'd100, 16'd2);
      repeat (REPEAT_CLICKS) begin
         send_paced(2'd1, 1'b0);
         send_paced(2'd1, 1'b1);
      end
      repeat (2) send_paced(2'd1, 1'b1);

      wait_idle();
      $display("Checked %0d response transactions over %0d register settings,",
               tracker.ticks_seen, settings_total);
      $display("with %0d receiver hold-off(s); events seen: %0d single, %0d double, %0d long.",
               hold_offs_done, tracker.event_tally[EV_SINGLE],
               tracker.event_tally[EV_DOUBLE], tracker.event_tally[EV_LONG]);
      if (tracker.error_total == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Response pacing: segments of random length, each with its own stall
   // pattern, and on request one long hold-off counted here.
   initial begin : rsp_pacing
      int            hold_left;
      int            seg_left;
      pace_mode_type mode;
      hold_left = 0;
      seg_left  = 0;
      mode      = PACE_OPEN;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_offs_done++;
            hold_left = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(1, 40);
               mode     = pace_mode_type'($urandom_range(0, 3));
            end
            seg_left--;
            case (mode)
               PACE_OPEN:   rsp_ready <= 1'b1;
               PACE_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               PACE_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               default:     rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Every accepted response transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_event_kind, rsp_event_button, rsp_led_bits);
   end

   // The run is declared hung when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles.", WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

endmodule
